FILE: src/twnf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// twnf_pkg
// Shared constants and types of the biweight scan noise filter.
// ----------------------------------------------------------------------------
package twnf_pkg;

  localparam int MAX_HALF_WINDOW = 16;
  localparam int COORD_BITS      = 20;
  localparam int RING_DEPTH      = 2 * MAX_HALF_WINDOW + 1;
  localparam int RING_AW         = $clog2(RING_DEPTH + 1);
  localparam int POINT_BITS      = 2 * COORD_BITS;
  localparam int JUDGE_BITS      = $clog2(MAX_HALF_WINDOW + 2);
  localparam int HALF_BITS       = 5;
  localparam int SUM_BITS        = 18;
  localparam int CFG_DATA_BITS   = 18;
  localparam int CFG_INDEX_BITS  = 2;

  localparam logic [CFG_INDEX_BITS-1:0] REG_RANGE_SCALED_MODE = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_TUKEY_K           = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_WEIGHT_THRESHOLD  = 2'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_WINDOW_HALF       = 2'd3;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD_CENTER,
    OP_CENTER_SQ,
    OP_SQRT_STEP,
    OP_KEFF,
    OP_K2,
    OP_NB_SQ,
    OP_D2,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_ACC,
    OP_EMIT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   last;
  } dp_cmd_t;

  typedef struct packed {
    logic out_busy;
  } dp_status_t;

endpackage

`default_nettype wire

FILE: src/twnf_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// twnf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module twnf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: src/twnf_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// twnf_ctrl
// Sequencer: ring bookkeeping, window walk and datapath commands.
// ----------------------------------------------------------------------------
module twnf_ctrl (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  input  wire logic                             in_last,
  output logic                                  in_ready,
  input  wire logic                             mode,
  input  wire logic [twnf_pkg::HALF_BITS-1:0]   window_half,
  input  wire twnf_pkg::dp_status_t             status,
  output twnf_pkg::dp_cmd_t                     cmd,
  output logic                                  ram_we,
  output logic      [twnf_pkg::RING_AW-1:0]     ram_waddr,
  output logic      [twnf_pkg::RING_AW-1:0]     ram_raddr
);

  typedef enum logic [3:0] {
    S_IDLE, S_DECIDE, S_C_RD, S_C_LD, S_C_SQ, S_SQRT, S_KEFF, S_K2,
    S_N_RD, S_N_SQ, S_N_D2, S_N_DI, S_N_DS, S_N_ACC, S_EMIT
  } state_t;

  localparam int AW = twnf_pkg::RING_AW;
  localparam int JW = twnf_pkg::JUDGE_BITS;

  state_t                         state_r;
  logic [AW-1:0]                  wp_r;
  logic [AW-1:0]                  fill_r;
  logic [JW-1:0]                  judged_r;
  logic                           end_r;
  logic [AW-1:0]                  age_r;
  logic [AW-1:0]                  a_r;
  logic [AW-1:0]                  hi_r;
  logic [4:0]                     step_r;
  logic [twnf_pkg::HALF_BITS-1:0] w;
  logic [AW-1:0]                  w_ext;
  logic [AW-1:0]                  age_nxt;
  logic [AW:0]                    hi_sum;
  logic [AW-1:0]                  fill_m1;
  logic                           need;
  logic [AW-1:0]                  rd_age;
  logic [AW:0]                    slot_raw;

  assign w = (window_half > twnf_pkg::HALF_BITS'(twnf_pkg::MAX_HALF_WINDOW))
             ? twnf_pkg::HALF_BITS'(twnf_pkg::MAX_HALF_WINDOW) : window_half;
  assign w_ext   = AW'(w);
  assign age_nxt = AW'(judged_r) - AW'(1);
  assign hi_sum  = {1'b0, age_nxt} + {1'b0, w_ext};
  assign fill_m1 = fill_r - AW'(1);
  assign need    = end_r ? (judged_r != '0) : (JW'(w) < judged_r);

  assign rd_age   = (state_r == S_C_RD) ? age_r : a_r;
  assign slot_raw = {1'b0, wp_r} + (AW + 1)'(twnf_pkg::RING_DEPTH - 1) - {1'b0, rd_age};
  assign ram_raddr = (slot_raw >= (AW + 1)'(twnf_pkg::RING_DEPTH))
                     ? AW'(slot_raw - (AW + 1)'(twnf_pkg::RING_DEPTH)) : AW'(slot_raw);

  assign in_ready  = (state_r == S_IDLE);
  assign ram_we    = in_ready && in_valid;
  assign ram_waddr = wp_r;

  always_comb begin
    cmd.last = end_r && (judged_r == JW'(1));
    unique case (state_r)
      S_C_LD:  cmd.op = twnf_pkg::OP_LOAD_CENTER;
      S_C_SQ:  cmd.op = twnf_pkg::OP_CENTER_SQ;
      S_SQRT:  cmd.op = twnf_pkg::OP_SQRT_STEP;
      S_KEFF:  cmd.op = twnf_pkg::OP_KEFF;
      S_K2:    cmd.op = twnf_pkg::OP_K2;
      S_N_SQ:  cmd.op = twnf_pkg::OP_NB_SQ;
      S_N_D2:  cmd.op = twnf_pkg::OP_D2;
      S_N_DI:  cmd.op = twnf_pkg::OP_DIV_INIT;
      S_N_DS:  cmd.op = twnf_pkg::OP_DIV_STEP;
      S_N_ACC: cmd.op = twnf_pkg::OP_ACC;
      S_EMIT:  cmd.op = status.out_busy ? twnf_pkg::OP_NONE : twnf_pkg::OP_EMIT;
      default: cmd.op = twnf_pkg::OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      wp_r     <= '0;
      fill_r   <= '0;
      judged_r <= '0;
      end_r    <= 1'b0;
      age_r    <= '0;
      a_r      <= '0;
      hi_r     <= '0;
      step_r   <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            wp_r <= (wp_r == AW'(twnf_pkg::RING_DEPTH - 1)) ? '0 : wp_r + AW'(1);
            if (fill_r < AW'(twnf_pkg::RING_DEPTH)) begin
              fill_r <= fill_r + AW'(1);
            end
            if (judged_r < JW'(twnf_pkg::MAX_HALF_WINDOW + 1)) begin
              judged_r <= judged_r + JW'(1);
            end
            end_r   <= in_last;
            state_r <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          if (need) begin
            age_r   <= age_nxt;
            a_r     <= (age_nxt >= w_ext) ? age_nxt - w_ext : '0;
            hi_r    <= (hi_sum > {1'b0, fill_m1}) ? fill_m1 : AW'(hi_sum);
            state_r <= S_C_RD;
          end else begin
            if (end_r) begin
              fill_r <= '0;
            end
            state_r <= S_IDLE;
          end
        end
        S_C_RD: state_r <= S_C_LD;
        S_C_LD: state_r <= S_C_SQ;
        S_C_SQ: begin
          step_r  <= '0;
          state_r <= mode ? S_SQRT : S_KEFF;
        end
        S_SQRT: begin
          step_r <= step_r + 5'd1;
          if (step_r == 5'd19) begin
            state_r <= S_KEFF;
          end
        end
        S_KEFF: state_r <= S_K2;
        S_K2:   state_r <= S_N_RD;
        S_N_RD: state_r <= S_N_SQ;
        S_N_SQ: state_r <= S_N_D2;
        S_N_D2: state_r <= S_N_DI;
        S_N_DI: begin
          step_r  <= '0;
          state_r <= S_N_DS;
        end
        S_N_DS: begin
          step_r <= step_r + 5'd1;
          if (step_r == 5'd11) begin
            state_r <= S_N_ACC;
          end
        end
        S_N_ACC: begin
          if (a_r == hi_r) begin
            state_r <= S_EMIT;
          end else begin
            a_r     <= a_r + AW'(1);
            state_r <= S_N_RD;
          end
        end
        S_EMIT: begin
          if (!status.out_busy) begin
            judged_r <= judged_r - JW'(1);
            state_r  <= S_DECIDE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: src/twnf_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// twnf_dp
// Arithmetic: center range, cutoff, biweight terms, sum and result word.
// ----------------------------------------------------------------------------
module twnf_dp (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire twnf_pkg::dp_cmd_t                   cmd,
  output twnf_pkg::dp_status_t                     status,
  input  wire logic [twnf_pkg::POINT_BITS-1:0]     rdata,
  input  wire logic                                mode,
  input  wire logic [15:0]                         tukey_k,
  input  wire logic [twnf_pkg::SUM_BITS-1:0]       threshold,
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  output logic      [twnf_pkg::POINT_BITS-1:0]     out_tdata,
  output logic                                     out_tuser,
  output logic                                     out_tlast
);

  localparam int CB = twnf_pkg::COORD_BITS;

  logic signed [CB-1:0]         cx_r;
  logic signed [CB-1:0]         cy_r;
  logic        [2*CB-1:0]       sq_src_r;
  logic        [CB+2:0]         sq_rem_r;
  logic        [CB-1:0]         sq_root_r;
  logic        [23:0]           keff_r;
  logic        [47:0]           k2_r;
  logic        [2*CB+1:0]       dx2_r;
  logic        [2*CB+1:0]       dy2_r;
  logic        [2*CB+2:0]       d2_r;
  logic        [48:0]           div_r;
  logic        [12:0]           q_r;
  logic                         skip_r;
  logic        [twnf_pkg::SUM_BITS-1:0] sum_r;
  logic                         out_valid_r;

  logic signed [2*CB-1:0]       cx2;
  logic signed [2*CB-1:0]       cy2;
  logic        [CB+2:0]         rem_t;
  logic        [CB+2:0]         trial;
  logic signed [CB:0]           dx;
  logic signed [CB:0]           dy;
  logic signed [2*CB+1:0]       dx2;
  logic signed [2*CB+1:0]       dy2;
  logic        [35:0]           kr;
  logic        [47:0]           d2w;
  logic        [48:0]           r0;
  logic        [48:0]           shl;
  logic        [25:0]           qq;

  assign cx2   = cx_r * cx_r;
  assign cy2   = cy_r * cy_r;
  assign rem_t = {sq_rem_r[CB:0], sq_src_r[2*CB-1:2*CB-2]};
  assign trial = {1'b0, sq_root_r, 2'b01};
  assign dx    = $signed({rdata[CB-1], rdata[CB-1:0]}) - $signed({cx_r[CB-1], cx_r});
  assign dy    = $signed({rdata[2*CB-1], rdata[2*CB-1:CB]}) - $signed({cy_r[CB-1], cy_r});
  assign dx2   = dx * dx;
  assign dy2   = dy * dy;
  assign kr    = 36'(tukey_k) * 36'(sq_root_r);
  assign d2w   = 48'(d2_r);
  assign r0    = {1'b0, k2_r - d2w};
  assign shl   = {div_r[47:0], 1'b0};
  assign qq    = 26'(q_r) * 26'(q_r);

  assign status.out_busy = out_valid_r && !out_tready;
  assign out_tvalid      = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.op == twnf_pkg::OP_EMIT) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      twnf_pkg::OP_LOAD_CENTER: begin
        cx_r  <= rdata[CB-1:0];
        cy_r  <= rdata[2*CB-1:CB];
        sum_r <= '0;
      end
      twnf_pkg::OP_CENTER_SQ: begin
        sq_src_r  <= $unsigned(cx2) + $unsigned(cy2);
        sq_rem_r  <= '0;
        sq_root_r <= '0;
      end
      twnf_pkg::OP_SQRT_STEP: begin
        sq_src_r <= {sq_src_r[2*CB-3:0], 2'b00};
        if (rem_t >= trial) begin
          sq_rem_r  <= rem_t - trial;
          sq_root_r <= {sq_root_r[CB-2:0], 1'b1};
        end else begin
          sq_rem_r  <= rem_t;
          sq_root_r <= {sq_root_r[CB-2:0], 1'b0};
        end
      end
      twnf_pkg::OP_KEFF: begin
        keff_r <= mode ? kr[35:12] : 24'(tukey_k);
      end
      twnf_pkg::OP_K2: begin
        k2_r <= 48'(keff_r) * 48'(keff_r);
      end
      twnf_pkg::OP_NB_SQ: begin
        dx2_r <= dx2;
        dy2_r <= dy2;
      end
      twnf_pkg::OP_D2: begin
        d2_r <= {1'b0, dx2_r} + {1'b0, dy2_r};
      end
      twnf_pkg::OP_DIV_INIT: begin
        if (d2w > k2_r) begin
          skip_r <= 1'b1;
          q_r    <= '0;
        end else if (k2_r == '0) begin
          skip_r <= 1'b1;
          q_r    <= 13'd4096;
        end else begin
          skip_r <= 1'b0;
          if (r0 >= {1'b0, k2_r}) begin
            div_r <= r0 - {1'b0, k2_r};
            q_r   <= 13'd1;
          end else begin
            div_r <= r0;
            q_r   <= 13'd0;
          end
        end
      end
      twnf_pkg::OP_DIV_STEP: begin
        if (!skip_r) begin
          if (shl >= {1'b0, k2_r}) begin
            div_r <= shl - {1'b0, k2_r};
            q_r   <= {q_r[11:0], 1'b1};
          end else begin
            div_r <= shl;
            q_r   <= {q_r[11:0], 1'b0};
          end
        end
      end
      twnf_pkg::OP_ACC: begin
        sum_r <= sum_r + twnf_pkg::SUM_BITS'(qq[25:12]);
      end
      twnf_pkg::OP_EMIT: begin
        out_tdata <= {cy_r, cx_r};
        out_tuser <= (sum_r > threshold);
        out_tlast <= cmd.last;
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: src/tukey_window_noise_filter.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tukey_window_noise_filter
// Biweight neighbour density filter for the points of one laser scan.
// ----------------------------------------------------------------------------
// Points enter on the in_ stream in scan order, tlast on the final point.
// Each result word on the out_ stream carries one judged point, unchanged,
// with tuser set when its biweight sum exceeds weight_threshold and tlast
// set on the result for the scan's final point. A point is judged once
// window_half later points have arrived; tlast on input flushes the rest.
// The block takes one point, then judges due points one at a time. A judged
// point reads its center and, in scaled mode, takes the range square root;
// then each window point costs one read of the ring RAM and a restoring
// divide, with up to 33 window points in a full window. The output register
// holds a finished word while the receiver stalls; the sequencer waits
// only when a second word is ready. Reset empties the ring and loads the
// register defaults; the configuration port may be written at any time
// the block is idle.
// ----------------------------------------------------------------------------
module tukey_window_noise_filter (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  in_tvalid,
  output logic                                       in_tready,
  // pos_x [19:0], pos_y [39:20]
  input  wire logic [twnf_pkg::POINT_BITS-1:0]       in_tdata,
  input  wire logic                                  in_tlast,
  output logic                                       out_tvalid,
  input  wire logic                                  out_tready,
  // out_x [19:0], out_y [39:20]
  output logic      [twnf_pkg::POINT_BITS-1:0]       out_tdata,
  // keep [0]
  output logic                                       out_tuser,
  output logic                                       out_tlast,
  input  wire logic                                  cfg_we,
  input  wire logic [twnf_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  wire logic [twnf_pkg::CFG_DATA_BITS-1:0]    cfg_data
);

  logic                                 mode_r;
  logic [15:0]                          tukey_k_r;
  logic [twnf_pkg::SUM_BITS-1:0]        threshold_r;
  logic [twnf_pkg::HALF_BITS-1:0]       window_half_r;
  twnf_pkg::dp_cmd_t                    cmd;
  twnf_pkg::dp_status_t                 status;
  logic                                 ram_we;
  logic [twnf_pkg::RING_AW-1:0]         ram_waddr;
  logic [twnf_pkg::RING_AW-1:0]         ram_raddr;
  logic [twnf_pkg::POINT_BITS-1:0]      ram_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r        <= 1'b1;
      tukey_k_r     <= 16'd410;
      threshold_r   <= twnf_pkg::SUM_BITS'(6144);
      window_half_r <= twnf_pkg::HALF_BITS'(8);
    end else if (cfg_we) begin
      unique case (cfg_index)
        twnf_pkg::REG_RANGE_SCALED_MODE: mode_r        <= cfg_data[0];
        twnf_pkg::REG_TUKEY_K:           tukey_k_r     <= cfg_data[15:0];
        twnf_pkg::REG_WEIGHT_THRESHOLD:  threshold_r   <= cfg_data;
        twnf_pkg::REG_WINDOW_HALF:       window_half_r <= cfg_data[4:0];
        default: begin
        end
      endcase
    end
  end

  twnf_ram #(
    .WIDTH (twnf_pkg::POINT_BITS),
    .DEPTH (2 ** twnf_pkg::RING_AW)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_tdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  twnf_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_tvalid),
    .in_last     (in_tlast),
    .in_ready    (in_tready),
    .mode        (mode_r),
    .window_half (window_half_r),
    .status      (status),
    .cmd         (cmd),
    .ram_we      (ram_we),
    .ram_waddr   (ram_waddr),
    .ram_raddr   (ram_raddr)
  );

  twnf_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .status     (status),
    .rdata      (ram_rdata),
    .mode       (mode_r),
    .tukey_k    (tukey_k_r),
    .threshold  (threshold_r),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input taken while a point is being processed");

  a_hold_while_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata) &&
                                     $stable(out_tuser) && $stable(out_tlast)))
    else $error("result word changed while the receiver stalled");

  a_result_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> !in_tready)
    else $error("result word appeared while the sequencer was idle");

endmodule

`default_nettype wire
